// File: hdl/sectp_pkg.sv
// Shared types, codes and helpers of the section timing profiler.
// Used by the statistics memory, the update datapath and the top level.
package sectp_pkg;

    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_END   = 2'd1;
    localparam logic [1:0] OP_RESET = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_IN_ERROR  = 3'd1;
    localparam logic [2:0] ST_DBL_BEGIN = 3'd2;
    localparam logic [2:0] ST_DBL_END   = 3'd3;
    localparam logic [2:0] ST_UNKNOWN   = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;
    localparam logic [2:0] ST_END_RESET = 3'd6;

    localparam logic [2:0] MODE_RESET     = 3'd0;
    localparam logic [2:0] MODE_RUNNING   = 3'd1;
    localparam logic [2:0] MODE_STOPPED   = 3'd2;
    localparam logic [2:0] MODE_DBL_BEGIN = 3'd3;
    localparam logic [2:0] MODE_DBL_END   = 3'd4;

    localparam logic [31:0] MIN_CLEAR = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] start;
        logic [31:0] count;
        logic [63:0] total;
        logic [31:0] min_time;
        logic [31:0] max_time;
    } t_stats;

    typedef struct packed {
        logic        wr;
        logic [2:0]  status;
        t_stats      stats;
    } t_upd;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot;
        logic [2:0]  mode;
        logic [31:0] count;
        logic [63:0] total;
        logic [31:0] min_time;
        logic [31:0] max_time;
        logic [4:0]  used;
    } t_res;

    function automatic t_stats f_clear_stats(input logic [31:0] start);
        t_stats s;
        s.mode     = MODE_RESET;
        s.start    = start;
        s.count    = 32'd0;
        s.total    = 64'd0;
        s.min_time = MIN_CLEAR;
        s.max_time = 32'd0;
        return s;
    endfunction

    function automatic t_res f_res_empty(input logic [2:0] status, input logic [3:0] slot,
                                         input logic [4:0] used);
        t_res r;
        r.status   = status;
        r.slot     = slot;
        r.mode     = MODE_RESET;
        r.count    = 32'd0;
        r.total    = 64'd0;
        r.min_time = 32'd0;
        r.max_time = 32'd0;
        r.used     = used;
        return r;
    endfunction

endpackage

// File: hdl/sectp_tag_mem.sv
// Tag memory of the profiler: one 32-bit section tag per entry.
// One write port, one registered read port; no package use.
module sectp_tag_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);

    logic [31:0] mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/sectp_stat_mem.sv
// Statistics memory of the profiler: start, count, total, min, max and mode
// per entry. One write port, one registered read port; uses sectp_pkg.
module sectp_stat_mem
    import sectp_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_stats        i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_stats        o_rdata
);

    t_stats mem [DEPTH];
    t_stats r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/sectp_upd.sv
// Update datapath: applies a begin, end or read to one entry read from the
// statistics memory and gives the status and the entry to write back. Uses sectp_pkg.
module sectp_upd
    import sectp_pkg::*;
(
    input  logic [1:0]  i_op,
    input  t_stats      i_old,
    input  logic [31:0] i_now,
    output t_upd        o_upd
);

    logic [31:0] diff;
    logic        in_error;

    assign diff     = i_now - i_old.start;
    assign in_error = (i_old.mode == MODE_DBL_BEGIN) || (i_old.mode == MODE_DBL_END);

    always_comb begin
        o_upd.wr     = 1'b0;
        o_upd.status = ST_OK;
        o_upd.stats  = i_old;
        case (i_op)
            OP_BEGIN: begin
                if (in_error) begin
                    o_upd.status = ST_IN_ERROR;
                end else if (i_old.mode == MODE_RUNNING) begin
                    o_upd.wr         = 1'b1;
                    o_upd.status     = ST_DBL_BEGIN;
                    o_upd.stats.mode = MODE_DBL_BEGIN;
                end else begin
                    o_upd.wr          = 1'b1;
                    o_upd.stats.start = i_now;
                    o_upd.stats.mode  = MODE_RUNNING;
                end
            end
            OP_END: begin
                if (i_old.mode == MODE_RESET) begin
                    o_upd.status = ST_END_RESET;
                end else if (in_error) begin
                    o_upd.status = ST_IN_ERROR;
                end else if (i_old.mode == MODE_STOPPED) begin
                    o_upd.wr         = 1'b1;
                    o_upd.status     = ST_DBL_END;
                    o_upd.stats.mode = MODE_DBL_END;
                end else begin
                    // running: close the interval
                    o_upd.wr          = 1'b1;
                    o_upd.stats.count = i_old.count + 32'd1;
                    o_upd.stats.total = i_old.total + {32'd0, diff};
                    if (i_old.max_time < diff) begin
                        o_upd.stats.max_time = diff;
                    end
                    if (i_old.min_time > diff) begin
                        o_upd.stats.min_time = diff;
                    end
                    o_upd.stats.mode = MODE_STOPPED;
                end
            end
            default: begin
                // read: return the entry unchanged
                o_upd.wr = 1'b0;
            end
        endcase
    end

endmodule

// File: hdl/section_timing_profiler.sv
// Top level of the section timing profiler: command sequencer, tag walk,
// entry count and output register. Uses sectp_pkg, sectp_tag_mem,
// sectp_stat_mem and sectp_upd.
//
//  channel  | dir | tdata                                   | tuser
//  ---------+-----+-----------------------------------------+-----------------
//  s (cmd)  | in  | tag_key, timestamp, read_index          | opcode
//  m (resp) | out | slot, entry_mode, call_count, total,    | status
//           |     | min_time, max_time, used_entries        |
//
// One command at a time. Begin/end walk the tags at one per cycle until the tag is
// found or the used entries run out. Reset of all statistics rewrites one entry
// per cycle. A read past the used entries answers without reading the statistics
// memory. The stores need no clearing pass after reset. A new command is taken
// while the previous word still waits on the output; a stalled output holds the
// sequencer in its emit step.
module section_timing_profiler
    import sectp_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [71:0]  i_s_tdata,   // tag_key[31:0], timestamp[63:32], read_index[67:64]
    input  logic [1:0]   i_s_tuser,   // opcode[1:0]
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [175:0] o_m_tdata,   // slot[3:0], entry_mode[6:4], call_count[38:7],
                                      // total_time[102:39], min_time[134:103],
                                      // max_time[166:135], used_entries[171:167]
    output logic [2:0]   o_m_tuser    // status[2:0]
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int UW = IW + 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SRCH = 5'b00010,
        S_UPD  = 5'b00100,
        S_CLR  = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    t_state       r_state, n_state;
    logic [UW-1:0] r_addr, n_addr;
    logic          r_pend, n_pend;
    logic [IW-1:0] r_cidx, n_cidx;
    logic [UW-1:0] r_used, n_used;
    logic [1:0]    r_op;
    logic [31:0]   r_key, r_now;
    t_res          r_res, n_res;
    t_res          r_out;
    logic          r_ovalid;

    logic          tag_we, tag_re;
    logic [IW-1:0] tag_waddr, tag_raddr;
    logic [31:0]   tag_rdata;
    logic          st_we, st_re;
    logic [IW-1:0] st_waddr, st_raddr;
    t_stats        st_wdata, st_rdata;
    t_upd          upd;

    logic          accept, out_load, hit;
    logic [UW+3:0] ridx_x, used_x;
    t_stats        alloc_stats;

    function automatic logic [3:0] f_slot(input logic [IW-1:0] idx);
        logic [IW+3:0] x;
        x = {4'd0, idx};
        return x[3:0];
    endfunction

    function automatic logic [4:0] f_used5(input logic [UW-1:0] u);
        logic [UW+4:0] x;
        x = {5'd0, u};
        return x[4:0];
    endfunction

    sectp_tag_mem #(.DEPTH(ENTRIES), .AW(IW)) u_tag_mem (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (tag_waddr),
        .i_wdata (r_key),
        .i_re    (tag_re),
        .i_raddr (tag_raddr),
        .o_rdata (tag_rdata)
    );

    sectp_stat_mem #(.DEPTH(ENTRIES), .AW(IW)) u_stat_mem (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (st_re),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    sectp_upd u_upd (
        .i_op  (r_op),
        .i_old (st_rdata),
        .i_now (r_now),
        .o_upd (upd)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign out_load   = (r_state == S_EMIT) && (!r_ovalid || i_m_tready);
    assign hit        = r_pend && (tag_rdata == r_key);
    assign ridx_x     = {{UW{1'b0}}, i_s_tdata[67:64]};
    assign used_x     = {4'd0, r_used};

    always_comb begin
        alloc_stats      = f_clear_stats(r_now);
        alloc_stats.mode = MODE_RUNNING;
    end

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_pend    = r_pend;
        n_cidx    = r_cidx;
        n_used    = r_used;
        n_res     = r_res;
        tag_we    = 1'b0;
        tag_waddr = r_used[IW-1:0];
        tag_re    = 1'b0;
        tag_raddr = r_addr[IW-1:0];
        st_we     = 1'b0;
        st_waddr  = r_cidx;
        st_wdata  = upd.stats;
        st_re     = 1'b0;
        st_raddr  = r_cidx;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_addr = '0;
                    n_pend = 1'b0;
                    case (i_s_tuser)
                        OP_BEGIN, OP_END: n_state = S_SRCH;
                        OP_RESET:         n_state = S_CLR;
                        default: begin
                            if (ridx_x < used_x) begin
                                st_re    = 1'b1;
                                st_raddr = ridx_x[IW-1:0];
                                n_cidx   = ridx_x[IW-1:0];
                                n_state  = S_UPD;
                            end else begin
                                n_res   = f_res_empty(ST_UNKNOWN, i_s_tdata[67:64],
                                                      f_used5(r_used));
                                n_state = S_EMIT;
                            end
                        end
                    endcase
                end
            end
            S_SRCH: begin
                if (hit) begin
                    st_re   = 1'b1;
                    n_state = S_UPD;
                end else if (r_addr < r_used) begin
                    // issue the next tag while the previous one is compared
                    tag_re = 1'b1;
                    n_cidx = r_addr[IW-1:0];
                    n_addr = r_addr + UW'(1);
                    n_pend = 1'b1;
                end else if (r_op == OP_BEGIN && r_used < UW'(ENTRIES)) begin
                    tag_we         = 1'b1;
                    st_we          = 1'b1;
                    st_waddr       = r_used[IW-1:0];
                    st_wdata       = alloc_stats;
                    n_used         = r_used + UW'(1);
                    n_res          = f_res_empty(ST_OK, f_slot(r_used[IW-1:0]),
                                                 f_used5(r_used + UW'(1)));
                    n_res.mode     = MODE_RUNNING;
                    n_res.min_time = MIN_CLEAR;
                    n_state        = S_EMIT;
                end else begin
                    n_res   = f_res_empty((r_op == OP_BEGIN) ? ST_FULL : ST_UNKNOWN, 4'd0,
                                          f_used5(r_used));
                    n_state = S_EMIT;
                end
            end
            S_UPD: begin
                st_we          = upd.wr;
                n_res.status   = upd.status;
                n_res.slot     = f_slot(r_cidx);
                n_res.mode     = upd.stats.mode;
                n_res.count    = upd.stats.count;
                n_res.total    = upd.stats.total;
                n_res.min_time = upd.stats.min_time;
                n_res.max_time = upd.stats.max_time;
                n_res.used     = f_used5(r_used);
                n_state        = S_EMIT;
            end
            S_CLR: begin
                if (r_addr < r_used) begin
                    st_we    = 1'b1;
                    st_waddr = r_addr[IW-1:0];
                    st_wdata = f_clear_stats(32'd0);
                    n_addr   = r_addr + UW'(1);
                end else begin
                    n_res   = f_res_empty(ST_OK, 4'd0, f_used5(r_used));
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_ovalid <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_pend  <= n_pend;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_cidx <= n_cidx;
        r_res  <= n_res;
        if (accept) begin
            r_op  <= i_s_tuser;
            r_key <= i_s_tdata[31:0];
            r_now <= i_s_tdata[63:32];
        end
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_out.status;
    assign o_m_tdata  = {4'd0, r_out.used, r_out.max_time, r_out.min_time, r_out.total,
                         r_out.count, r_out.mode, r_out.slot};

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(ENTRIES))
        else $error("entry count above table depth");

    a_used_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_used == $past(r_used) || r_used == $past(r_used) + UW'(1)))
        else $error("entry count moved by more than one");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == ST_FULL) |-> (r_used == UW'(ENTRIES)))
        else $error("table full reported with free entries");

    a_alloc_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tag_we |-> (st_we && st_waddr == tag_waddr && n_used == r_used + UW'(1)))
        else $error("tag written without its statistics");

endmodule

// File: verif/section_timing_profiler_checker.sv
// Checker for the section timing profiler: watches the command and response
// channels, predicts each response word and compares it field by field.
// Depends on sectp_pkg for the opcode, status and mode codes and on t_res.
module section_timing_profiler_checker
    import sectp_pkg::*;
#(
    parameter int NUM_ENTRIES = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [71:0]  i_s_tdata,   // tag_key[31:0], timestamp[63:32], read_index[67:64]
    input  logic [1:0]   i_s_tuser,   // opcode[1:0]
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [175:0] i_m_tdata,   // slot[3:0], entry_mode[6:4], call_count[38:7],
                                      // total_time[102:39], min_time[134:103],
                                      // max_time[166:135], used_entries[171:167]
    input  logic [2:0]   i_m_tuser,   // status[2:0]
    output int           o_mismatches,
    output int           o_words_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // shadow of the section table
    logic [31:0] sec_tag   [NUM_ENTRIES];
    logic [31:0] sec_start [NUM_ENTRIES];
    logic [31:0] sec_count [NUM_ENTRIES];
    logic [63:0] sec_total [NUM_ENTRIES];
    logic [31:0] sec_min   [NUM_ENTRIES];
    logic [31:0] sec_max   [NUM_ENTRIES];
    logic [2:0]  sec_mode  [NUM_ENTRIES];
    int unsigned sec_used;

    t_res awaited_results[$];
    t_res predicted_word;
    t_res want_word;
    t_res got_word;
    int   mismatch_count;
    int   checked_count;

    assign o_mismatches = mismatch_count;

    task automatic flag_mismatch(input string what);
        $display("%0t ns: response mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got %0h expected %0h (word %0d)",
                                    name, got, want, checked_count));
    endtask

    function automatic void clear_section(input int idx);
        sec_start[idx] = 32'd0;
        sec_count[idx] = 32'd0;
        sec_total[idx] = 64'd0;
        sec_min[idx]   = MIN_CLEAR;
        sec_max[idx]   = 32'd0;
        sec_mode[idx]  = MODE_RESET;
    endfunction

    function automatic logic in_error(input logic [2:0] mode);
        return mode == MODE_DBL_BEGIN || mode == MODE_DBL_END;
    endfunction

    // response word for a status and an entry; no entry gives zeroed fields
    function automatic t_res section_word(input logic [2:0] status, input int idx);
        t_res r;
        r = '0;
        r.status = status;
        if (idx >= 0) begin
            r.slot     = 4'(idx);
            r.mode     = sec_mode[idx];
            r.count    = sec_count[idx];
            r.total    = sec_total[idx];
            r.min_time = sec_min[idx];
            r.max_time = sec_max[idx];
        end
        r.used = 5'(sec_used);
        return r;
    endfunction

    function automatic t_res profile_step(input logic [1:0] op, input logic [31:0] key,
                                          input logic [31:0] now, input logic [3:0] ridx);
        int          hit;
        logic [31:0] span;
        t_res        r;
        hit = -1;
        for (int j = 0; j < int'(sec_used); j++)
            if (hit < 0 && sec_tag[j] == key)
                hit = j;
        case (op)
            OP_BEGIN: begin
                if (hit < 0) begin
                    if (sec_used >= NUM_ENTRIES)
                        return section_word(ST_FULL, -1);
                    hit = int'(sec_used);
                    sec_tag[hit] = key;
                    clear_section(hit);
                    sec_used++;
                end else begin
                    if (in_error(sec_mode[hit]))
                        return section_word(ST_IN_ERROR, hit);
                    if (sec_mode[hit] == MODE_RUNNING) begin
                        sec_mode[hit] = MODE_DBL_BEGIN;
                        return section_word(ST_DBL_BEGIN, hit);
                    end
                end
                sec_start[hit] = now;
                sec_mode[hit]  = MODE_RUNNING;
                return section_word(ST_OK, hit);
            end
            OP_END: begin
                if (hit < 0)
                    return section_word(ST_UNKNOWN, -1);
                if (sec_mode[hit] == MODE_RESET)
                    return section_word(ST_END_RESET, hit);
                if (in_error(sec_mode[hit]))
                    return section_word(ST_IN_ERROR, hit);
                if (sec_mode[hit] == MODE_STOPPED) begin
                    sec_mode[hit] = MODE_DBL_END;
                    return section_word(ST_DBL_END, hit);
                end
                span = now - sec_start[hit];
                sec_count[hit] = sec_count[hit] + 32'd1;
                sec_total[hit] = sec_total[hit] + {32'd0, span};
                if (sec_max[hit] < span)
                    sec_max[hit] = span;
                if (sec_min[hit] > span)
                    sec_min[hit] = span;
                sec_mode[hit] = MODE_STOPPED;
                return section_word(ST_OK, hit);
            end
            OP_RESET: begin
                for (int j = 0; j < int'(sec_used); j++)
                    clear_section(j);
                return section_word(ST_OK, -1);
            end
            default: begin
                if (ridx >= sec_used) begin
                    r = section_word(ST_UNKNOWN, -1);
                    r.slot = ridx;
                    return r;
                end
                return section_word(ST_OK, int'(ridx));
            end
        endcase
    endfunction

    initial begin
        mismatch_count = 0;
        checked_count  = 0;
        sec_used       = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sec_used = 0;
            awaited_results.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                predicted_word  = profile_step(i_s_tuser, i_s_tdata[31:0],
                                               i_s_tdata[63:32], i_s_tdata[67:64]);
                awaited_results = {awaited_results, predicted_word};
            end
            if (i_m_tvalid && i_m_tready) begin
                got_word.status   = i_m_tuser;
                got_word.slot     = i_m_tdata[3:0];
                got_word.mode     = i_m_tdata[6:4];
                got_word.count    = i_m_tdata[38:7];
                got_word.total    = i_m_tdata[102:39];
                got_word.min_time = i_m_tdata[134:103];
                got_word.max_time = i_m_tdata[166:135];
                got_word.used     = i_m_tdata[171:167];
                if (awaited_results.size() == 0) begin
                    flag_mismatch($sformatf("word with nothing awaited, status %0d",
                                            got_word.status));
                end else begin
                    want_word = awaited_results.pop_front();
                    compare_field("status", got_word.status, want_word.status);
                    compare_field("slot", got_word.slot, want_word.slot);
                    compare_field("entry_mode", got_word.mode, want_word.mode);
                    compare_field("call_count", got_word.count, want_word.count);
                    compare_field("total_time", got_word.total, want_word.total);
                    compare_field("min_time", got_word.min_time, want_word.min_time);
                    compare_field("max_time", got_word.max_time, want_word.max_time);
                    compare_field("used_entries", got_word.used, want_word.used);
                end
                checked_count++;
            end
        end
        o_words_checked <= checked_count;
    end

endmodule

// File: verif/section_timing_profiler_test.sv
// Testbench top of the section timing profiler: clock, reset, command stimulus,
// response back-pressure, watchdog and verdict.
// Depends on sectp_pkg, section_timing_profiler and section_timing_profiler_checker.
module section_timing_profiler_test
    import sectp_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 1333;
    localparam int PRESSURE_AT  = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [71:0]  s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [175:0] m_tdata;
    logic [2:0]   m_tuser;
    int           mismatches;
    int           words_checked;
    int           words_sent;
    int           idle_cycles;

    logic [31:0]  tag_pool [16];
    logic         open_sec [16];
    int unsigned  send_quiet;
    int unsigned  recv_quiet;

    section_timing_profiler #(.ENTRIES(16)) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    section_timing_profiler_checker #(.NUM_ENTRIES(16)) u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_tvalid      (s_tvalid),
        .i_s_tready      (s_tready),
        .i_s_tdata       (s_tdata),
        .i_s_tuser       (s_tuser),
        .i_m_tvalid      (m_tvalid),
        .i_m_tready      (m_tready),
        .i_m_tdata       (m_tdata),
        .i_m_tuser       (m_tuser),
        .o_mismatches    (mismatches),
        .o_words_checked (words_checked)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // random idle gaps between words, with occasional stretches of back-to-back words
    function automatic int unsigned pick_wait(inout int unsigned quiet_left);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) begin
            quiet_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    task automatic push_cmd(input logic [1:0] op, input logic [31:0] key,
                            input logic [31:0] ts, input logic [3:0] ridx);
        int unsigned gap;
        gap = pick_wait(send_quiet);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'd0, ridx, ts, key};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        words_sent++;
    endtask

    // response side: random stalls, plus one long hold-off to back up the block
    initial begin
        bit          held;
        int unsigned stall;
        held = 1'b0;
        recv_quiet = 0;
        m_tready <= 1'b0;
        forever begin
            if (!held && words_sent >= PRESSURE_AT) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            stall = pick_wait(recv_quiet);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        logic [1:0]  op;
        logic [31:0] key;
        logic [31:0] now_ticks;
        int unsigned roll;
        int unsigned pick;
        words_sent  = 0;
        idle_cycles = 0;
        send_quiet  = 0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_BEGIN;
        tag_pool[0] = 32'd0;
        tag_pool[1] = 32'hFFFF_FFFF;
        for (int j = 2; j < 16; j++)
            tag_pool[j] = $urandom;
        for (int j = 0; j < 16; j++)
            open_sec[j] = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty table, wrap of the elapsed time, errors, reset
        push_cmd(OP_READ,  32'd0,       32'd0,          4'd0);
        push_cmd(OP_END,   tag_pool[0], 32'd0,          4'd0);
        push_cmd(OP_BEGIN, tag_pool[0], 32'd0,          4'd0);
        push_cmd(OP_END,   tag_pool[0], 32'hFFFF_FFFF,  4'd15);  // above the min bound
        push_cmd(OP_BEGIN, tag_pool[0], 32'hFFFF_FFF0,  4'd0);
        push_cmd(OP_END,   tag_pool[0], 32'h0000_0010,  4'd0);   // wraps to a short span
        push_cmd(OP_END,   tag_pool[0], 32'h0000_0020,  4'd0);   // double end
        push_cmd(OP_END,   tag_pool[0], 32'h0000_0030,  4'd0);   // stuck in error
        push_cmd(OP_BEGIN, tag_pool[0], 32'h0000_0040,  4'd0);
        push_cmd(OP_BEGIN, tag_pool[1], 32'd7,          4'd0);
        push_cmd(OP_BEGIN, tag_pool[1], 32'd9,          4'd0);   // double begin
        push_cmd(OP_END,   tag_pool[1], 32'd11,         4'd0);
        push_cmd(OP_READ,  32'd0,       32'd0,          4'd1);
        push_cmd(OP_RESET, 32'd0,       32'd0,          4'd0);
        push_cmd(OP_END,   tag_pool[1], 32'd13,         4'd0);   // end on a cleared entry
        push_cmd(OP_READ,  32'd0,       32'd0,          4'd15);  // past the used entries
        push_cmd(OP_READ,  32'd0,       32'd0,          4'd0);

        // random: mostly begin/end pairs on a pool of tags, with noise tags
        now_ticks = $urandom;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 6)
                op = OP_RESET;
            else if (roll < 18)
                op = OP_READ;
            else if (roll < 60)
                op = OP_BEGIN;
            else
                op = OP_END;
            if ($urandom_range(0, 29) == 0)
                now_ticks = $urandom;
            else
                now_ticks = now_ticks + $urandom_range(1, 300);
            // steer begins to closed sections and ends to open ones
            pick = $urandom_range(0, 15);
            for (int t = 0; t < 4; t++)
                if (open_sec[pick] != (op == OP_END))
                    pick = $urandom_range(0, 15);
            key = tag_pool[pick];
            if ($urandom_range(0, 99) < 8) begin
                key = $urandom;
            end else if (op == OP_BEGIN) begin
                open_sec[pick] = 1'b1;
            end else if (op == OP_END) begin
                open_sec[pick] = 1'b0;
            end
            if (op == OP_RESET)
                for (int j = 0; j < 16; j++)
                    open_sec[j] = 1'b0;
            push_cmd(op, key, now_ticks, 4'($urandom));
        end
        s_tvalid <= 1'b0;

        while (words_checked < words_sent) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && words_checked == words_sent)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
